// ===== hdl/cstk_pkg.sv =====
package cstk_pkg;

   localparam int VECTOR_LENGTH = 128;
   localparam int MAX_VECTORS   = 8192;

   localparam int ELEM_W  = 16;
   localparam int ID_W    = $clog2(MAX_VECTORS);
   localparam int ACC_W   = 40;
   localparam int ROOT_W  = 20;
   localparam int DEN_W   = 40;
   localparam int NUM_W   = 56;
   localparam int SCORE_W = 16;
   localparam int KEEP_W  = 9;
   localparam logic [KEEP_W-1:0] KEEP_RESET = 9'd200;

   localparam logic OP_ELEM = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef struct packed {
      logic                      op;
      logic signed [ELEM_W-1:0]  elem_a;
      logic signed [ELEM_W-1:0]  elem_b;
      logic [ID_W-1:0]           id_a;
      logic [ID_W-1:0]           id_b;
      logic                      last_elem;
   } req_type;

   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic [ID_W-1:0]           pair_first;
      logic [ID_W-1:0]           pair_second;
      logic                      store_empty;
   } rsp_type;

   // Work handed from the front part to the back part.
   typedef struct packed {
      logic                      pop;
      logic [ACC_W-1:0]          dot;
      logic [ACC_W-1:0]          norm_a;
      logic [ACC_W-1:0]          norm_b;
      logic [ID_W-1:0]           id_a;
      logic [ID_W-1:0]           id_b;
   } job_type;

   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic [ID_W-1:0]           first;
      logic [ID_W-1:0]           second;
   } entry_type;

   // Strict order: score, then id_a, then id_b.
   function automatic logic entry_less(input entry_type x, input entry_type y);
      logic r;
      if (x.score != y.score) begin
         r = x.score < y.score;
      end else if (x.first != y.first) begin
         r = x.first < y.first;
      end else begin
         r = x.second < y.second;
      end
      return r;
   endfunction

endpackage

// ===== hdl/cstk_if.sv =====
interface cstk_if #(parameter int W = 1);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/cosine_similarity_top_k.sv =====
// Element items: one per cycle, no result; the last element queues a score job and
// waits while the queue is full. Score job: 20 root steps, 56 divide steps (skipped
// for a zero norm) and a scan of the kept entries (at least one step).
// Pop: once the back part is free, the result follows a scan of the kept entries and
// the removal of the lowest one, if any, and is held until the taker accepts it.
// Synchronous active-high reset clears accumulators, fill and keep_count=200.
module cosine_similarity_top_k #(
   parameter int CAPACITY = 256
) (
   input  logic clock,
   input  logic reset,
   cstk_if.sink   req,
   cstk_if.sink   csr,
   cstk_if.source rsp
);
   cstk_pkg::req_type req_data;
   cstk_pkg::job_type fj, bj;
   logic fv, fr, bv, br;
   logic [cstk_pkg::KEEP_W-1:0] keep_ff;

   assign req_data  = req.data;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff <= cstk_pkg::KEEP_RESET;
      end else if (csr.valid) begin
         keep_ff <= csr.data[cstk_pkg::KEEP_W-1:0];
      end
   end

   cstk_front u_front (
      .clock, .reset, .in_valid(req.valid), .in_ready(req.ready), .in_data(req_data),
      .job_valid(fv), .job_ready(fr), .job_data(fj)
   );

   cstk_queue #(.DEPTH(2)) u_queue (
      .clock, .reset, .wr_valid(fv), .wr_ready(fr), .wr_data(fj),
      .rd_valid(bv), .rd_ready(br), .rd_data(bj)
   );

   cstk_back #(.CAPACITY(CAPACITY)) u_back (
      .clock, .reset, .keep_count(keep_ff), .job_valid(bv), .job_ready(br), .job_data(bj),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
   );
endmodule

// ===== hdl/cstk_front.sv =====
module cstk_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  cstk_pkg::req_type    in_data,
   output logic                 job_valid,
   input  logic                 job_ready,
   output cstk_pkg::job_type    job_data
);
   logic [cstk_pkg::ACC_W-1:0] dot_ff, dot_in, na_ff, na_in, nb_ff, nb_in;
   logic signed [2*cstk_pkg::ELEM_W-1:0] pab, paa, pbb;
   logic take;

   assign pab = in_data.elem_a * in_data.elem_b;
   assign paa = in_data.elem_a * in_data.elem_a;
   assign pbb = in_data.elem_b * in_data.elem_b;

   assign take = in_valid && in_ready;

   // Element items without the last flag never need the queue.
   assign in_ready = (in_data.op == cstk_pkg::OP_ELEM && !in_data.last_elem) || job_ready;
   assign job_valid = in_valid && (in_data.op == cstk_pkg::OP_POP || in_data.last_elem);

   always_comb begin
      dot_in = dot_ff + {{(cstk_pkg::ACC_W-32){pab[31]}}, pab};
      na_in  = na_ff + {{(cstk_pkg::ACC_W-32){1'b0}}, paa};
      nb_in  = nb_ff + {{(cstk_pkg::ACC_W-32){1'b0}}, pbb};
      job_data.pop    = in_data.op;
      job_data.dot    = dot_in;
      job_data.norm_a = na_in;
      job_data.norm_b = nb_in;
      job_data.id_a   = in_data.id_a;
      job_data.id_b   = in_data.id_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff <= '0;
         na_ff  <= '0;
         nb_ff  <= '0;
      end else if (take && in_data.op == cstk_pkg::OP_ELEM) begin
         if (in_data.last_elem) begin
            dot_ff <= '0;
            na_ff  <= '0;
            nb_ff  <= '0;
         end else begin
            dot_ff <= dot_in;
            na_ff  <= na_in;
            nb_ff  <= nb_in;
         end
      end
   end
endmodule

// ===== hdl/cstk_queue.sv =====
module cstk_queue #(
   parameter int DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_valid,
   output logic                 wr_ready,
   input  cstk_pkg::job_type    wr_data,
   output logic                 rd_valid,
   input  logic                 rd_ready,
   output cstk_pkg::job_type    rd_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   cstk_pkg::job_type mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0]   cnt_ff;
   logic wr, rd;

   assign wr_ready = cnt_ff != (AW+1)'(DEPTH);
   assign rd_valid = cnt_ff != '0;
   assign rd_data  = mem_ff[rp_ff];
   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wp_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr) begin
            wp_ff <= (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
         end
         if (rd) begin
            rp_ff <= (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + (AW+1)'(wr) - (AW+1)'(rd);
      end
   end
endmodule

// ===== hdl/cstk_back.sv =====
module cstk_back #(
   parameter int CAPACITY = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [cstk_pkg::KEEP_W-1:0]   keep_count,
   input  logic                          job_valid,
   output logic                          job_ready,
   input  cstk_pkg::job_type             job_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output cstk_pkg::rsp_type             out_data
);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int NW = cstk_pkg::NUM_W;
   localparam int DW = cstk_pkg::DEN_W;
   localparam int RW = cstk_pkg::ROOT_W;

   typedef enum logic [3:0] {
      S_IDLE, S_SQRT, S_MUL, S_DIV, S_RND, S_SAT, S_SCAN, S_SCAN_WAIT, S_DECIDE,
      S_MOVE_RD, S_MOVE_WR, S_OUT
   } state_type;

   state_type state_ff;
   cstk_pkg::entry_type mem [CAPACITY];
   cstk_pkg::entry_type rd_q, new_ff, min_ff;
   logic [AW-1:0] rd_addr, min_idx_ff, scan_ff;
   logic [CW-1:0] kept_ff;
   logic          pop_ff, neg_ff, scan_first_ff;
   logic [cstk_pkg::ACC_W-1:0] xa_ff, xb_ff, mag_ff;
   logic [RW-1:0] ra_ff, rb_ff, bitv_ff;
   logic [DW-1:0] den_ff;
   logic [NW-1:0] num_ff, quo_ff;
   logic [NW:0]   rem_ff;
   logic [5:0]    cnt_ff;
   logic [CW-1:0] limit;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   cstk_pkg::entry_type wr_val;
   cstk_pkg::rsp_type   out_ff;

   assign job_ready = state_ff == S_IDLE;
   assign out_valid = state_ff == S_OUT;
   assign out_data  = out_ff;
   assign limit = ({{(32-cstk_pkg::KEEP_W){1'b0}}, keep_count} > CAPACITY) ?
                  CW'(CAPACITY) : CW'(keep_count);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_val;
      end
      rd_q <= mem[rd_addr];
   end

   // Square root: one result bit per cycle for each norm.
   logic [cstk_pkg::ACC_W-1:0] sa_sq, sb_sq;
   assign sa_sq = {{(cstk_pkg::ACC_W-RW){1'b0}}, ra_ff | bitv_ff} *
                  {{(cstk_pkg::ACC_W-RW){1'b0}}, ra_ff | bitv_ff};
   assign sb_sq = {{(cstk_pkg::ACC_W-RW){1'b0}}, rb_ff | bitv_ff} *
                  {{(cstk_pkg::ACC_W-RW){1'b0}}, rb_ff | bitv_ff};

   logic [NW:0] rem_sh;
   assign rem_sh = {rem_ff[NW-1:0], num_ff[NW-1]};

   always_comb begin
      rd_addr = scan_ff;
      wr_en   = 1'b0;
      wr_addr = kept_ff[AW-1:0];
      wr_val  = new_ff;
      if (state_ff == S_MOVE_RD) begin
         rd_addr = AW'(kept_ff - 1'b1);
      end
      if (state_ff == S_DECIDE && !pop_ff) begin
         if (kept_ff < limit) begin
            wr_en = 1'b1;
         end else if (limit != '0 && kept_ff != '0 && new_ff.score > min_ff.score) begin
            wr_en   = 1'b1;
            wr_addr = min_idx_ff;
         end
      end
      if (state_ff == S_MOVE_WR) begin
         wr_en   = 1'b1;
         wr_addr = min_idx_ff;
         wr_val  = rd_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kept_ff  <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (job_valid) begin
                  pop_ff <= job_data.pop;
                  new_ff.first  <= job_data.id_a;
                  new_ff.second <= job_data.id_b;
                  xa_ff <= job_data.norm_a;
                  xb_ff <= job_data.norm_b;
                  neg_ff <= job_data.dot[cstk_pkg::ACC_W-1];
                  mag_ff <= job_data.dot[cstk_pkg::ACC_W-1] ? -job_data.dot : job_data.dot;
                  ra_ff <= '0;
                  rb_ff <= '0;
                  bitv_ff <= {1'b1, {(RW-1){1'b0}}};
                  scan_ff <= '0;
                  scan_first_ff <= 1'b1;
                  state_ff <= job_data.pop ? S_SCAN : S_SQRT;
               end
            end
            S_SQRT: begin
               if (sa_sq <= xa_ff) ra_ff <= ra_ff | bitv_ff;
               if (sb_sq <= xb_ff) rb_ff <= rb_ff | bitv_ff;
               bitv_ff <= bitv_ff >> 1;
               if (bitv_ff[0]) state_ff <= S_MUL;
            end
            S_MUL: begin
               den_ff <= {{(DW-RW){1'b0}}, ra_ff} * {{(DW-RW){1'b0}}, rb_ff};
               state_ff <= S_RND;
            end
            S_RND: begin
               num_ff <= (NW'(mag_ff) << 15) + NW'(den_ff >> 1);
               rem_ff <= '0;
               quo_ff <= '0;
               cnt_ff <= 6'(NW);
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (den_ff == '0) begin
                  new_ff.score <= '0;
                  state_ff <= S_SCAN;
               end else begin
                  if (rem_sh >= {{(NW+1-DW){1'b0}}, den_ff}) begin
                     rem_ff <= rem_sh - {{(NW+1-DW){1'b0}}, den_ff};
                     quo_ff <= {quo_ff[NW-2:0], 1'b1};
                  end else begin
                     rem_ff <= rem_sh;
                     quo_ff <= {quo_ff[NW-2:0], 1'b0};
                  end
                  num_ff <= num_ff << 1;
                  cnt_ff <= cnt_ff - 1'b1;
                  if (cnt_ff == 6'd1) state_ff <= S_SAT;
               end
            end
            S_SAT: begin
               // Apply the sign and clamp to the Q1.15 range.
               if (neg_ff) begin
                  new_ff.score <= (quo_ff > NW'(32768)) ? 16'h8000 : -16'(quo_ff);
               end else begin
                  new_ff.score <= (quo_ff > NW'(32767)) ? 16'h7fff : 16'(quo_ff);
               end
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               state_ff <= S_SCAN_WAIT;
            end
            S_SCAN_WAIT: begin
               if (CW'(scan_ff) < kept_ff) begin
                  if (scan_first_ff || cstk_pkg::entry_less(rd_q, min_ff)) begin
                     min_ff <= rd_q;
                     min_idx_ff <= scan_ff;
                  end
                  scan_first_ff <= 1'b0;
               end
               if (CW'(scan_ff) + 1'b1 >= kept_ff) begin
                  state_ff <= S_DECIDE;
               end else begin
                  scan_ff <= scan_ff + 1'b1;
                  state_ff <= S_SCAN;
               end
            end
            S_DECIDE: begin
               if (!pop_ff) begin
                  if (kept_ff < limit) kept_ff <= kept_ff + 1'b1;
                  state_ff <= S_IDLE;
               end else if (kept_ff == '0) begin
                  out_ff <= '{score: '0, pair_first: '0, pair_second: '0, store_empty: 1'b1};
                  state_ff <= S_OUT;
               end else begin
                  out_ff <= '{score: min_ff.score, pair_first: min_ff.first,
                              pair_second: min_ff.second, store_empty: 1'b0};
                  state_ff <= S_MOVE_RD;
               end
            end
            S_MOVE_RD: state_ff <= S_MOVE_WR;
            S_MOVE_WR: begin
               kept_ff <= kept_ff - 1'b1;
               state_ff <= S_OUT;
            end
            S_OUT: if (out_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
